// ----- hw/rtl/rbd_pkg.sv -----
// Shared types, constants and codes for the RSSI burst detector.
`default_nettype none

package rbd_pkg;

	// Field widths.
	localparam int unsigned RSSI_W     = 8;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned RUN_W      = 16;
	localparam int unsigned CNT8_W     = 8;
	localparam int unsigned WIN_CNT_W  = 5;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Saturation limit of the run and length counters.
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Register reset values.
	localparam logic signed [RSSI_W-1:0] FLOOR_RST   = -8'sd100;
	localparam logic signed [RSSI_W-1:0] CEILING_RST = -8'sd20;
	localparam logic signed [RSSI_W-1:0] THRESH_RST  = -8'sd70;
	localparam logic [CNT8_W-1:0]        ENTER_RST   = 8'd2;
	localparam logic [CNT8_W-1:0]        EXIT_RST    = 8'd2;
	localparam logic [TIME_W-1:0]        WINDOW_RST  = 32'd60000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOOR   = 3'd0,
		CFG_CEILING = 3'd1,
		CFG_THRESH  = 3'd2,
		CFG_ENTER   = 3'd3,
		CFG_EXIT    = 3'd4,
		CFG_WINDOW  = 3'd5
	} cfg_reg_t;

	// Item sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WALK,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Pending update of the gap average.
	typedef enum logic [1:0] {
		AVG_NONE,
		AVG_SEED,
		AVG_BLEND
	} avg_op_t;

	// Action codes of an input item.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	typedef struct packed {
		logic                     action;
		logic signed [RSSI_W-1:0] rssi_dbm;
		logic [TIME_W-1:0]        now_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [RSSI_W-1:0] rssi_clamped;
		logic                     burst_active;
		logic                     burst_ended;
		logic [TIME_W-1:0]        burst_total;
		logic [TIME_W-1:0]        last_gap_ms;
		logic [TIME_W-1:0]        average_gap_ms;
		logic [WIN_CNT_W-1:0]     bursts_in_window;
		logic [RUN_W-1:0]         last_burst_length;
	} out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbd_ifs.sv -----
// Channel interfaces of the RSSI burst detector: samples, results and configuration.
`default_nettype none

interface rbd_sample_if import rbd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rbd_result_if import rbd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rbd_cfg_if import rbd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rbd_ring_mem.sv -----
// Synchronous single-port-write, single-port-read memory for burst end times.
`default_nettype none

module rbd_ring_mem import rbd_pkg::*; #(
	parameter int unsigned DEPTH = 30,
	parameter int unsigned AW    = 5
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [TIME_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [TIME_W-1:0] rd_data_q
);

	logic [TIME_W-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rbd_classify.sv -----
// Clamps a sample to the floor and ceiling and compares it with the threshold.
`default_nettype none

module rbd_classify import rbd_pkg::*; (
	input  wire logic signed [RSSI_W-1:0] rssi,
	input  wire logic signed [RSSI_W-1:0] floor_lvl,
	input  wire logic signed [RSSI_W-1:0] ceiling_lvl,
	input  wire logic signed [RSSI_W-1:0] thresh_lvl,
	output logic signed      [RSSI_W-1:0] clamped,
	output logic                          above
);

	// The floor test wins when the floor lies above the ceiling.
	always_comb begin
		if (rssi <= floor_lvl) begin
			clamped = floor_lvl;
		end else if (rssi >= ceiling_lvl) begin
			clamped = ceiling_lvl;
		end else begin
			clamped = rssi;
		end
		above = clamped > thresh_lvl;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/rssi_burst_detector_stats.sv -----
// Top level of the RSSI burst detector with burst statistics.
// Usage:
//   samples: one item per RSSI sample (action, rssi_dbm, now_ms); action set
//     clears all statistics instead. cfg: register writes, always ready, made
//     only while the block is idle, a rule for the user that the block itself
//     does not enforce. results: one item for every sample item.
// Timing:
//   A sample that does not close a burst passes the evaluate and emit states
//   to the result register, and the next item is taken in the idle state.
//   A sample that closes a burst stores its end time in the end-time memory and
//   then reads back every filled entry, one per cycle through the memory's read
//   port, to count the recent ends, then passes the drain and emit states.
//   One item is in work at a time.
// Reset: all statistics and the registers go to their reset values at once;
//   the memory needs no clearing, since only entries already written are read.
// Stall: a finished result waits in the output register; a following item is
//   accepted and worked on, and its result waits until the register is free.
`default_nettype none

module rssi_burst_detector_stats import rbd_pkg::*; #(
	parameter int unsigned END_RING_DEPTH = 30
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rbd_sample_if.sink samples,
	rbd_result_if.source results,
	rbd_cfg_if.sink    cfg
);

	localparam int unsigned IDX_W  = (END_RING_DEPTH > 1) ? $clog2(END_RING_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(END_RING_DEPTH + 1);

	// Configuration registers.
	logic signed [RSSI_W-1:0] floor_q, ceiling_q, thresh_q;
	logic [CNT8_W-1:0]        enter_q, exit_q;
	logic [TIME_W-1:0]        window_q;

	// Sequencer and item registers.
	state_t   state_q, state_d;
	in_item_t item_q;
	logic     in_rdy, rd_en, wr_en, out_load;

	// Detector and statistics state.
	logic                     in_burst_q;
	logic [RUN_W-1:0]         above_run_q, below_run_q, cur_len_q, prev_len_q;
	logic [TIME_W-1:0]        completed_q, last_end_q, gap_q, gap_avg_q;
	logic [IDX_W-1:0]         head_q;
	logic [FILL_W-1:0]        fill_q, rate_q;
	avg_op_t                  avg_op_q;
	logic signed [RSSI_W-1:0] r_q;
	logic                     ended_q;

	// Window walk.
	logic [FILL_W-1:0] walk_cnt_q, walk_next, count_q, count_next;
	logic              rd_valid_s1, walk_last, hit;
	logic [TIME_W-1:0] rd_data, age;

	// Output register.
	logic      out_valid_q;
	out_item_t out_q;

	// Classification and hysteresis decisions.
	logic signed [RSSI_W-1:0] clamped;
	logic                     above;
	logic [RUN_W-1:0]         above_inc, below_inc, cur_inc;
	logic                     start_now, close_now;
	logic [TIME_W+1:0]        avg_sum;

	function automatic logic [RUN_W-1:0] inc_sat(input logic [RUN_W-1:0] v);
		return (v == RUN_MAX) ? RUN_MAX : v + RUN_W'(1);
	endfunction

	rbd_classify u_classify (
		.rssi        (item_q.rssi_dbm),
		.floor_lvl   (floor_q),
		.ceiling_lvl (ceiling_q),
		.thresh_lvl  (thresh_q),
		.clamped     (clamped),
		.above       (above)
	);

	rbd_ring_mem #(
		.DEPTH (END_RING_DEPTH),
		.AW    (IDX_W)
	) u_ring (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (head_q),
		.wr_data   (item_q.now_ms),
		.rd_en     (rd_en),
		.rd_addr   (walk_cnt_q[IDX_W-1:0]),
		.rd_data_q (rd_data)
	);

	// Configuration writes; indexes past the list are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= FLOOR_RST;
			ceiling_q <= CEILING_RST;
			thresh_q  <= THRESH_RST;
			enter_q   <= ENTER_RST;
			exit_q    <= EXIT_RST;
			window_q  <= WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FLOOR:   floor_q   <= cfg.data[RSSI_W-1:0];
				CFG_CEILING: ceiling_q <= cfg.data[RSSI_W-1:0];
				CFG_THRESH:  thresh_q  <= cfg.data[RSSI_W-1:0];
				CFG_ENTER:   enter_q   <= cfg.data[CNT8_W-1:0];
				CFG_EXIT:    exit_q    <= cfg.data[CNT8_W-1:0];
				CFG_WINDOW:  window_q  <= cfg.data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Hysteresis decisions for the item in the evaluate cycle.
	always_comb begin
		above_inc = inc_sat(above_run_q);
		below_inc = inc_sat(below_run_q);
		cur_inc   = inc_sat(cur_len_q);
		start_now = (item_q.action == ACT_SAMPLE) && !in_burst_q && above &&
			(above_inc >= RUN_W'(enter_q));
		close_now = (item_q.action == ACT_SAMPLE) && in_burst_q && !above &&
			(below_inc >= RUN_W'(exit_q));
	end

	// Window walk: age of each stored end time against the current time.
	always_comb begin
		walk_next  = walk_cnt_q + FILL_W'(1);
		walk_last  = (walk_next == fill_q);
		age        = item_q.now_ms - rd_data;
		hit        = rd_valid_s1 && (age <= window_q);
		count_next = count_q + FILL_W'(hit);
		avg_sum    = {1'b0, gap_avg_q, 1'b0} + {2'b00, gap_avg_q} + {2'b00, gap_q};
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d  = state_q;
		in_rdy   = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_rdy = 1'b1;
				if (samples.valid) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				wr_en   = close_now;
				state_d = close_now ? ST_WALK : ST_EMIT;
			end
			ST_WALK: begin
				rd_en = 1'b1;
				if (walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign samples.ready = in_rdy;

	// Accepted item.
	always_ff @(posedge clk) begin
		if (in_rdy && samples.valid) begin
			item_q <= samples.data;
		end
	end

	// Detector and statistics update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_burst_q  <= 1'b0;
			above_run_q <= '0;
			below_run_q <= '0;
			cur_len_q   <= '0;
			prev_len_q  <= '0;
			completed_q <= '0;
			last_end_q  <= '0;
			gap_q       <= '0;
			gap_avg_q   <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			rate_q      <= '0;
			avg_op_q    <= AVG_NONE;
			r_q         <= '0;
			ended_q     <= 1'b0;
			walk_cnt_q  <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (rd_valid_s1) begin
				count_q <= count_next;
			end

			case (state_q)
				ST_EVAL: begin
					if (item_q.action == ACT_CLEAR) begin
						in_burst_q  <= 1'b0;
						above_run_q <= '0;
						below_run_q <= '0;
						cur_len_q   <= '0;
						prev_len_q  <= '0;
						completed_q <= '0;
						last_end_q  <= '0;
						gap_q       <= '0;
						gap_avg_q   <= '0;
						head_q      <= '0;
						fill_q      <= '0;
						rate_q      <= '0;
						avg_op_q    <= AVG_NONE;
						r_q         <= '0;
						ended_q     <= 1'b0;
					end else begin
						r_q     <= clamped;
						ended_q <= close_now;
						if (!in_burst_q) begin
							if (above) begin
								above_run_q <= above_inc;
								if (start_now) begin
									in_burst_q  <= 1'b1;
									below_run_q <= '0;
									cur_len_q   <= above_inc;
								end
							end else begin
								above_run_q <= '0;
							end
						end else if (above) begin
							cur_len_q   <= cur_inc;
							below_run_q <= '0;
						end else begin
							below_run_q <= below_inc;
						end

						// Burst end: record it and start the window walk.
						if (close_now) begin
							in_burst_q  <= 1'b0;
							above_run_q <= '0;
							prev_len_q  <= cur_len_q;
							cur_len_q   <= '0;
							if (fill_q != '0) begin
								gap_q <= item_q.now_ms - last_end_q;
							end
							if (fill_q == '0) begin
								avg_op_q <= AVG_NONE;
							end else if (fill_q == FILL_W'(1)) begin
								avg_op_q <= AVG_SEED;
							end else begin
								avg_op_q <= AVG_BLEND;
							end
							last_end_q  <= item_q.now_ms;
							completed_q <= completed_q + TIME_W'(1);
							head_q      <= (head_q == IDX_W'(END_RING_DEPTH - 1)) ?
								'0 : head_q + IDX_W'(1);
							if (fill_q != FILL_W'(END_RING_DEPTH)) begin
								fill_q <= fill_q + FILL_W'(1);
							end
							walk_cnt_q <= '0;
							count_q    <= '0;
						end
					end
				end
				ST_WALK: begin
					walk_cnt_q <= walk_next;
					// The gap average is settled while the walk runs.
					case (avg_op_q)
						AVG_SEED:  gap_avg_q <= gap_q;
						AVG_BLEND: gap_avg_q <= avg_sum[TIME_W+1:2];
						default: ;
					endcase
					avg_op_q <= AVG_NONE;
				end
				ST_DRAIN: begin
					rate_q <= count_next;
				end
				default: ;
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.rssi_clamped      <= r_q;
			out_q.burst_active      <= in_burst_q;
			out_q.burst_ended       <= ended_q;
			out_q.burst_total       <= completed_q;
			out_q.last_gap_ms       <= gap_q;
			out_q.average_gap_ms    <= gap_avg_q;
			out_q.bursts_in_window  <= WIN_CNT_W'(rate_q);
			out_q.last_burst_length <= prev_len_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rbd_checker.sv -----
// Port-level checks of the RSSI burst detector and their bind to the top level.
`default_nettype none

module rbd_checker import rbd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A waiting result is not withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A waiting result does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// One item is worked on at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in work");

	// A closing sample leaves no burst active.
	a_end_not_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.burst_ended && out_data.burst_active))
		else $error("burst reported both ended and active");

	// A closed burst has at least one sample.
	a_end_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.burst_ended |-> out_data.last_burst_length != '0)
		else $error("closed burst reported with zero length");

endmodule

bind rssi_burst_detector_stats rbd_checker u_rbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

`default_nettype wire
